@@ rtl/bsc_pkg.sv @@
package bsc_pkg;

   localparam int unsigned MAX_VECTOR_LENGTH = 65536;
   localparam int unsigned FLIP_CNT_W = 17;
   localparam int unsigned FLIP_CNT_LIMIT = (1 << FLIP_CNT_W) - 1;
   localparam logic [FLIP_CNT_W-1:0] FLIP_COUNT_MAX =
      FLIP_CNT_W'((MAX_VECTOR_LENGTH < FLIP_CNT_LIMIT) ? MAX_VECTOR_LENGTH : FLIP_CNT_LIMIT);

   localparam int unsigned GEN_W = 31;
   localparam logic [GEN_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
   localparam logic [14:0] LEHMER_MULT = 15'd16807;
   localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ERROR_THRESHOLD = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GENERATOR_SEED = 8'd2;

   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_INVERT = 2'd1;
   localparam logic [1:0] MODE_RANDOM = 2'd2;

   typedef struct packed {
      logic in_bit;
      logic end_of_vector;
   } req_type;

   typedef struct packed {
      logic                  out_bit;
      logic                  was_flipped;
      logic [FLIP_CNT_W-1:0] flip_count;
      logic                  vector_done;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       channel_mode;
      logic [GEN_W-1:0] error_threshold;
      logic             seed_load;
      logic [GEN_W-1:0] seed_state;
   } cfg_type;

endpackage

@@ rtl/bsc_csr.sv @@
module bsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]  csr_data,
   output bsc_pkg::cfg_type                 cfg
);

   logic [1:0]                mode_ff;
   logic [bsc_pkg::GEN_W-1:0] threshold_ff;
   logic                      write;
   logic [bsc_pkg::GEN_W-1:0] seed_raw;

   assign csr_ready = 1'b1;
   assign write = csr_valid && csr_ready;
   assign seed_raw = csr_data[bsc_pkg::GEN_W-1:0];

   // zero and the modulus lock the generator
   always_comb begin
      cfg.channel_mode = mode_ff;
      cfg.error_threshold = threshold_ff;
      cfg.seed_load = write && (csr_index == bsc_pkg::REG_GENERATOR_SEED);
      if ((seed_raw == '0) || (seed_raw == bsc_pkg::LEHMER_MOD)) begin
         cfg.seed_state = bsc_pkg::SEED_RESET;
      end else begin
         cfg.seed_state = seed_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bsc_pkg::MODE_PASS;
         threshold_ff <= '0;
      end else if (write) begin
         if (csr_index == bsc_pkg::REG_CHANNEL_MODE) begin
            mode_ff <= csr_data[1:0];
         end
         if (csr_index == bsc_pkg::REG_ERROR_THRESHOLD) begin
            threshold_ff <= csr_data[bsc_pkg::GEN_W-1:0];
         end
      end
   end

endmodule

@@ rtl/bsc_lehmer.sv @@
module bsc_lehmer (
   input  logic [bsc_pkg::GEN_W-1:0] state,
   output logic [bsc_pkg::GEN_W-1:0] next_state
);

   logic [45:0] prod;
   logic [31:0] fold;

   // x * 16807 mod 2^31-1: fold high bits onto low, one conditional subtract
   always_comb begin
      prod = 46'(state) * 46'(bsc_pkg::LEHMER_MULT);
      fold = {1'b0, prod[30:0]} + {17'b0, prod[45:31]};
      if (fold >= {1'b0, bsc_pkg::LEHMER_MOD}) begin
         fold = fold - {1'b0, bsc_pkg::LEHMER_MOD};
      end
      next_state = fold[bsc_pkg::GEN_W-1:0];
   end

endmodule

@@ rtl/binary_symmetric_channel.sv @@
// Path: a req transfer is held in the input register, then in the result register.
// Throughput: one bit per cycle while rsp_ready is high; the generator step (one
// 31x15 multiply and a modular fold) sits between the input and result registers.
// Reset: synchronous; clears both stages, mode 0, threshold 0, generator state 1,
// flip counter 0.
module binary_symmetric_channel (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bsc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bsc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]  csr_data
);

   bsc_pkg::cfg_type cfg;

   logic                           s1_valid_ff, s1_valid_in;
   bsc_pkg::req_type               s1_data_ff;
   logic                           out_valid_ff, out_valid_in;
   bsc_pkg::rsp_type               out_data_ff, out_data_in;
   logic [bsc_pkg::GEN_W-1:0]      gen_state_ff, gen_state_in;
   logic [bsc_pkg::FLIP_CNT_W-1:0] flip_cnt_ff, flip_cnt_in;

   logic                           out_load, s1_move, req_xfer, flip;
   logic [bsc_pkg::GEN_W-1:0]      gen_next;
   logic [bsc_pkg::FLIP_CNT_W-1:0] cnt_step;

   bsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bsc_lehmer u_lehmer (
      .state      (gen_state_ff),
      .next_state (gen_next)
   );

   assign out_load = !out_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && out_load;
   assign req_ready = !s1_valid_ff || out_load;
   assign req_xfer = req_valid && req_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   always_comb begin
      flip = 1'b0;
      gen_state_in = gen_state_ff;
      case (cfg.channel_mode)
         bsc_pkg::MODE_INVERT: begin
            flip = 1'b1;
         end
         bsc_pkg::MODE_RANDOM: begin
            flip = gen_next <= cfg.error_threshold;
            if (s1_move) begin
               gen_state_in = gen_next;
            end
         end
         default: begin
            flip = 1'b0;
         end
      endcase
      if (cfg.seed_load) begin
         gen_state_in = cfg.seed_state;
      end

      if (flip && (flip_cnt_ff < bsc_pkg::FLIP_COUNT_MAX)) begin
         cnt_step = flip_cnt_ff + 1'b1;
      end else begin
         cnt_step = flip_cnt_ff;
      end

      flip_cnt_in = flip_cnt_ff;
      if (s1_move) begin
         flip_cnt_in = s1_data_ff.end_of_vector ? '0 : cnt_step;
      end

      out_data_in.out_bit = s1_data_ff.in_bit ^ flip;
      out_data_in.was_flipped = flip;
      out_data_in.flip_count = cnt_step;
      out_data_in.vector_done = s1_data_ff.end_of_vector;

      s1_valid_in = req_xfer || (s1_valid_ff && !out_load);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         gen_state_ff <= bsc_pkg::SEED_RESET;
         flip_cnt_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         gen_state_ff <= gen_state_in;
         flip_cnt_ff <= flip_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

@@ rtl/bsc_checker.sv @@
module bsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bsc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.flip_count <= bsc_pkg::FLIP_COUNT_MAX)
      else $error("flip_count above saturation");

   a_flip_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_flipped |-> rsp_data.flip_count != '0)
      else $error("flipped bit not counted");

   a_first_after_reset: assert property (@(posedge clock)
      reset ##1 !req_valid |=> !rsp_valid)
      else $error("result without prior request");

endmodule

bind binary_symmetric_channel bsc_checker u_bsc_checker (.*);

@@ verif/testbench.sv @@
module testbench;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam longint unsigned GEN_MODULUS = 64'd2147483647;
   localparam longint unsigned GEN_MULTIPLIER = 64'd16807;
   localparam logic [30:0] GEN_LOCKED = 31'h7FFF_FFFF;
   localparam logic [16:0] FLIP_SATURATION = 17'd65536;
   localparam int LONG_VECTOR_BITS = 200;
   localparam int RANDOM_BITS = 1250;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bsc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bsc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bsc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   binary_symmetric_channel dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // channel model state
   logic [1:0] chan_mode = bsc_pkg::MODE_PASS;
   logic [30:0] flip_threshold = '0;
   logic [30:0] gen_value = bsc_pkg::SEED_RESET;
   logic [16:0] vector_flips = '0;

   bsc_pkg::req_type pending_bits[$];
   bsc_pkg::rsp_type expected_rsp_q[$];
   bsc_pkg::rsp_type want;

   int send_idle = 0;
   int recv_idle = 0;
   int send_gap = 0;
   int stall_left = 0;
   logic req_taken = 1'b0;
   int cycle_count = 0;
   int bits_sent = 0;
   int results_checked = 0;
   int vectors_done = 0;
   int error_count = 0;

   function automatic logic [30:0] seed_to_gen(input logic [30:0] seed);
      if (seed == '0 || seed == GEN_LOCKED)
         return 31'd1;
      return seed;
   endfunction

   function automatic logic [30:0] lehmer_advance(input logic [30:0] x);
      longint unsigned prod;
      prod = 64'(x) * GEN_MULTIPLIER;
      return 31'(prod % GEN_MODULUS);
   endfunction

   function automatic void apply_reg(input logic [bsc_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [bsc_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         bsc_pkg::REG_CHANNEL_MODE: chan_mode = value[1:0];
         bsc_pkg::REG_ERROR_THRESHOLD: flip_threshold = value[30:0];
         bsc_pkg::REG_GENERATOR_SEED: gen_value = seed_to_gen(value[30:0]);
         default: ;
      endcase
   endfunction

   function automatic void predict_channel(input bsc_pkg::req_type item);
      bsc_pkg::rsp_type r;
      logic flip;
      flip = 1'b0;
      if (chan_mode == bsc_pkg::MODE_INVERT) begin
         flip = 1'b1;
      end else if (chan_mode == bsc_pkg::MODE_RANDOM) begin
         gen_value = lehmer_advance(gen_value);
         flip = (gen_value <= flip_threshold);
      end
      if (flip && vector_flips < FLIP_SATURATION)
         vector_flips = vector_flips + 17'd1;
      r.out_bit = item.in_bit ^ flip;
      r.was_flipped = flip;
      r.flip_count = vector_flips;
      r.vector_done = item.end_of_vector;
      expected_rsp_q.push_back(r);
      if (item.end_of_vector)
         vector_flips = '0;
   endfunction

   function automatic int pick_gap(input int level);
      int roll;
      roll = $urandom_range(0, 99);
      if (level == 0)
         return 0;
      if (roll < ((level == 1) ? 70 : 35))
         return 0;
      if (roll < 94)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void queue_bit(input logic b, input logic last);
      bsc_pkg::req_type item;
      item.in_bit = b;
      item.end_of_vector = last;
      pending_bits.push_back(item);
   endfunction

   // sample at rising edge: predict on req transfer, check on rsp transfer
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            predict_channel(req_data);
            bits_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: bit %0d flip %0d count %0d done %0d",
                     rsp_data.out_bit, rsp_data.was_flipped, rsp_data.flip_count,
                     rsp_data.vector_done);
            end else begin
               want = expected_rsp_q.pop_front();
               results_checked++;
               if (rsp_data.vector_done === 1'b1)
                  vectors_done++;
               if (rsp_data.out_bit !== want.out_bit ||
                   rsp_data.was_flipped !== want.was_flipped ||
                   rsp_data.flip_count !== want.flip_count ||
                   rsp_data.vector_done !== want.vector_done) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"result %0d mismatch: expected bit %0d flip %0d count %0d",
                        " done %0d, got bit %0d flip %0d count %0d done %0d"},
                        results_checked, want.out_bit, want.was_flipped, want.flip_count,
                        want.vector_done, rsp_data.out_bit, rsp_data.was_flipped,
                        rsp_data.flip_count, rsp_data.vector_done);
               end
            end
         end
      end
   end

   // drive at falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_bits.size() != 0) begin
               req_data <= pending_bits.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap(send_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(recv_idle);
         end
      end
   end

   task automatic write_reg(input logic [bsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bsc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_bits.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
         expected_rsp_q.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int phases;
      int random_sent;
      int target;
      int len;
      int sel;
      logic [1:0] mode;
      logic [31:0] rnd;
      logic [31:0] thr;

      phases = 0;
      random_sent = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: pass through
      queue_bit(1'b0, 1'b0);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b1);
      queue_bit(1'b1, 1'b1);
      drain();

      write_reg(bsc_pkg::REG_CHANNEL_MODE, {30'd0, bsc_pkg::MODE_INVERT});
      queue_bit(1'b0, 1'b0);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b1, 1'b1);
      queue_bit(1'b0, 1'b1);
      drain();

      // unused mode code acts as pass
      write_reg(bsc_pkg::REG_CHANNEL_MODE, 32'hFFFF_FFFF);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b1);
      drain();

      // writes to unknown indexes are dropped
      write_reg(8'd3, 32'hFFFF_FFFF);
      write_reg(8'hFF, 32'hFFFF_FFFF);
      // threshold beyond range flips everything; zero seed falls back to one
      write_reg(bsc_pkg::REG_ERROR_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(bsc_pkg::REG_CHANNEL_MODE, {30'h2000_0000, bsc_pkg::MODE_RANDOM});
      write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'd0);
      queue_bit(1'b0, 1'b0);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b1);
      drain();

      // threshold zero never flips; locking seed falls back to one
      write_reg(bsc_pkg::REG_ERROR_THRESHOLD, 32'd0);
      write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'h7FFF_FFFF);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b1);
      drain();

      write_reg(bsc_pkg::REG_ERROR_THRESHOLD, 32'd2147483646);
      write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'd2147483646);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b1);
      drain();

      write_reg(bsc_pkg::REG_ERROR_THRESHOLD, 32'h4000_0000);
      write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'hFFFF_FFFF);
      queue_bit(1'b0, 1'b0);
      queue_bit(1'b1, 1'b0);
      queue_bit(1'b0, 1'b0);
      queue_bit(1'b1, 1'b1);
      drain();
      phases = 7;

      // one long vector in invert mode, counter climbs every bit
      write_reg(bsc_pkg::REG_CHANNEL_MODE, {30'd0, bsc_pkg::MODE_INVERT});
      for (int i = 0; i < LONG_VECTOR_BITS; i++)
         queue_bit(1'($urandom_range(0, 1)), i == LONG_VECTOR_BITS - 1);
      drain();
      phases++;

      while (random_sent < RANDOM_BITS) begin
         sel = $urandom_range(0, 9);
         mode = (sel < 6) ? bsc_pkg::MODE_RANDOM : (sel < 8) ? bsc_pkg::MODE_INVERT :
                (sel == 8) ? bsc_pkg::MODE_PASS : MODE_UNUSED;
         rnd = $urandom();
         write_reg(bsc_pkg::REG_CHANNEL_MODE, {rnd[31:2], mode});
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: thr = 32'd0;
               1: thr = 32'd2147483646;
               2: thr = 32'h7FFF_FFFF;
               3: thr = $urandom_range(0, 32'h1000_0000);
               default: thr = $urandom();
            endcase
            write_reg(bsc_pkg::REG_ERROR_THRESHOLD, thr);
         end
         if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 7))
               0: write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'd0);
               1: write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'h7FFF_FFFF);
               2: write_reg(bsc_pkg::REG_GENERATOR_SEED, 32'd1);
               default: write_reg(bsc_pkg::REG_GENERATOR_SEED, $urandom());
            endcase
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(bsc_pkg::CSR_INDEX_W'($urandom_range(3, 255)), $urandom());
         send_idle = $urandom_range(0, 2);
         recv_idle = $urandom_range(0, 2);
         target = $urandom_range(60, 200);
         while (target > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) :
                  $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               queue_bit(1'($urandom_range(0, 1)), i == len - 1);
            target -= len;
            random_sent += len;
         end
         drain();
         phases++;
      end

      send_idle = 0;
      recv_idle = 0;
      drain();
      repeat (8) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         error_count += expected_rsp_q.size();
         $display("%0d expected results never arrived", expected_rsp_q.size());
      end
      $display("sent %0d bits in %0d configurations, checked %0d results over %0d vectors",
         bits_sent, phases, results_checked, vectors_done);
      $display("covered pass, invert, unused and random modes, bad seeds and a long vector");
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
